>>> rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: request/response beat types,
// action, status and config register codes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

  // Field widths
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned OBJ_SIZE_W   = 16;
  localparam int unsigned ALIGN_W      = 4;
  localparam int unsigned SLOT_BYTES_W = 17;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults and reset values
  localparam int unsigned SLOTS_DEF    = 1024;
  localparam int unsigned OBJ_SIZE_RST = 64;
  localparam int unsigned ALIGN_RST    = 6;
  localparam int unsigned POOL_RST     = 1024;
  localparam int unsigned MIN_OBJ_SIZE = 8;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT  = 2'd2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL
  } fbpa_state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;
  } fbpa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_slots;
  } fbpa_rsp_t;

endpackage

>>> rtl/fbpa_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps

interface fbpa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fbpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Standalone, no package needed.
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free stack in RAM plus a countdown of
// untouched slots. Depends on fbpa_pkg, fbpa_stream_if and fbpa_ram.
//
//   Channel  Dir   Beat contents                                 Handshake
//   in_bus   in    action, slot_index                            valid/ready
//   out_bus  out   status, slot_out, byte_offset, free_slots     valid/ready
//   cfg_*    in    register index and data                       write enable
//
// Each request steps through accept (counter update, stack RAM access),
// RAM read data, then slot index times slot size into the output register.
// The next request is accepted as soon as the previous one leaves the
// multiply cycle, even if its response is still waiting in out_bus.
// rst_n is synchronous: counts and config return to reset values at once.
// A stalled out_bus holds the multiply step (S_MUL) until the output register frees.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
  parameter int unsigned SLOTS = fbpa_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbpa_stream_if.sink                     in_bus,
  fbpa_stream_if.source                   out_bus,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fbpa_pkg::*;

  localparam int unsigned AW      = $clog2(SLOTS);
  localparam int unsigned CW      = $clog2(SLOTS + 1);
  localparam int unsigned GW      = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned EFF_RST = (POOL_RST > SLOTS) ? SLOTS : POOL_RST;

  // Config registers
  logic [OBJ_SIZE_W-1:0]   obj_size_r;
  logic [ALIGN_W-1:0]      align_r;
  logic [COUNT_W-1:0]      pool_count_r;
  logic [SLOT_BYTES_W-1:0] slot_bytes_r;

  // Pool counters
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;

  fbpa_state_t state_r, state_nxt;

  // Per-request registers held from accept to output load
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                pop_r, pop_nxt;
  logic                fresh_hit_r, fresh_hit_nxt;
  logic [AW-1:0]       fresh_val_r;
  logic [COUNT_W-1:0]  free_cnt_r;
  logic [GW-1:0]       grant_r;

  // Output register
  logic      out_valid_r;
  fbpa_rsp_t rsp_r;

  logic                    accept;
  logic                    push;
  logic                    load_out;
  logic [CW-1:0]           eff_count;
  logic [31:0]             sum_now;
  logic [31:0]             sum_nxt;
  logic [SLOT_W-1:0]       ram_rdata;
  logic [OBJ_SIZE_W-1:0]   size_min;
  logic [SLOT_BYTES_W-1:0] align_mask;
  logic [SLOT_BYTES_W-1:0] slot_bytes;
  logic [OFFSET_W-1:0]     prod;

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = rsp_r;

  // Effective pool size, saturated to the stack depth
  assign eff_count = (32'(pool_count_r) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(pool_count_r);
  assign sum_now   = 32'(depth_r) + 32'(fresh_r);
  assign sum_nxt   = 32'(depth_nxt) + 32'(fresh_nxt);

  // Aligned slot size: max(size, 8) rounded up to a multiple of 2^align
  assign size_min   = (obj_size_r < OBJ_SIZE_W'(MIN_OBJ_SIZE)) ?
                      OBJ_SIZE_W'(MIN_OBJ_SIZE) : obj_size_r;
  assign align_mask = (SLOT_BYTES_W'(1) << align_r) - SLOT_BYTES_W'(1);
  assign slot_bytes = (SLOT_BYTES_W'(size_min) + align_mask) & ~align_mask;

  // Offset wraps at 32 bits
  assign prod = OFFSET_W'(grant_r) * OFFSET_W'(slot_bytes_r);

  // Request decode and counter update at accept
  always_comb begin
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    status_nxt    = ST_OK;
    pop_nxt       = 1'b0;
    fresh_hit_nxt = 1'b0;
    push          = 1'b0;
    if (accept) begin
      case (in_bus.data.action)
        ACT_ALLOC: begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - CW'(1);
            pop_nxt   = 1'b1;
          end else if (fresh_r != '0) begin
            fresh_nxt     = fresh_r - CW'(1);
            fresh_hit_nxt = 1'b1;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        ACT_FREE: begin
          if (sum_now >= 32'(eff_count) || 32'(depth_r) >= 32'(SLOTS)) begin
            status_nxt = ST_FULL;
          end else begin
            depth_nxt = depth_r + CW'(1);
            push      = 1'b1;
          end
        end
        ACT_RESET: begin
          depth_nxt = '0;
          fresh_nxt = eff_count;
        end
        default: ;
      endcase
    end
  end

  // Freed-slot stack
  fbpa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (depth_r[AW-1:0]),
    .wdata (in_bus.data.slot_index),
    .re    (pop_nxt),
    .raddr (depth_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: state_nxt = S_MUL;
      S_MUL: begin
        if (!out_valid_r || out_bus.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      depth_r      <= '0;
      fresh_r      <= CW'(EFF_RST);
      obj_size_r   <= OBJ_SIZE_W'(OBJ_SIZE_RST);
      align_r      <= ALIGN_W'(ALIGN_RST);
      pool_count_r <= COUNT_W'(POOL_RST);
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      fresh_r <= fresh_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_OBJECT_SIZE: obj_size_r   <= cfg_data;
          CFG_ALIGN_LOG2:  align_r      <= cfg_data[ALIGN_W-1:0];
          CFG_POOL_COUNT:  pool_count_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    slot_bytes_r <= slot_bytes;
    if (accept) begin
      status_r    <= status_nxt;
      pop_r       <= pop_nxt;
      fresh_hit_r <= fresh_hit_nxt;
      fresh_val_r <= fresh_nxt[AW-1:0];
      free_cnt_r  <= sum_nxt[COUNT_W-1:0];
    end
    if (state_r == S_READ) begin
      if (pop_r) begin
        grant_r <= GW'(ram_rdata);
      end else if (fresh_hit_r) begin
        grant_r <= GW'(fresh_val_r);
      end else begin
        grant_r <= '0;
      end
    end
    if (load_out) begin
      rsp_r.status      <= status_r;
      rsp_r.slot_out    <= grant_r[SLOT_W-1:0];
      rsp_r.byte_offset <= prod;
      rsp_r.free_slots  <= free_cnt_r;
    end
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(SLOTS))
    else $error("free stack depth beyond capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.data.action == ACT_ALLOC && depth_r != '0)
    |=> (depth_r == $past(depth_r) - CW'(1)))
    else $error("allocate from stack did not pop");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && out_valid_r && !out_bus.ready) |=> (state_r == S_MUL))
    else $error("result dropped while output stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.status != ST_OK)
    |-> (rsp_r.slot_out == '0 && rsp_r.byte_offset == '0))
    else $error("failed request reports a slot");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_bus.ready)
    else $error("request accepted while one is in flight");

endmodule
